// ----- rtl/cbrsu_pkg.sv -----
// Shared types, codes and constants of the bit, rotate, shift and flag unit.
package cbrsu_pkg;

   // Instruction group selected by the cmd field
   typedef enum logic [3:0] {
      CMD_PREFIX = 4'd0,
      CMD_RLCA   = 4'd1,
      CMD_RRCA   = 4'd2,
      CMD_RLA    = 4'd3,
      CMD_RRA    = 4'd4,
      CMD_DAA    = 4'd5,
      CMD_CPL    = 4'd6,
      CMD_SCF    = 4'd7,
      CMD_CCF    = 4'd8
   } cmd_type;

   // Prefixed opcode, bits 7-6
   typedef enum logic [1:0] {
      OPC_SHIFT = 2'd0,
      OPC_BIT   = 2'd1,
      OPC_RES   = 2'd2,
      OPC_SET   = 2'd3
   } opclass_type;

   // Prefixed opcode, bits 5-3, when the class is shift/rotate
   typedef enum logic [2:0] {
      SH_RLC  = 3'd0,
      SH_RRC  = 3'd1,
      SH_RL   = 3'd2,
      SH_RR   = 3'd3,
      SH_SLA  = 3'd4,
      SH_SRA  = 3'd5,
      SH_SWAP = 3'd6,
      SH_SRL  = 3'd7
   } shift_type;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [2:0] ACC_INDEX       = 3'd7;
   localparam logic [7:0] DAA_LOW_ADJ     = 8'h06;
   localparam logic [7:0] DAA_HIGH_ADJ    = 8'h60;
   localparam logic [7:0] DAA_HIGH_LIMIT  = 8'h99;
   localparam logic [3:0] DAA_DIGIT_LIMIT = 4'h9;

   typedef struct packed {
      logic [3:0] cmd;
      logic [7:0] prefix_opcode;
      logic [7:0] operand;
      logic [3:0] flags_in;
   } req_item_type;

   typedef struct packed {
      logic [7:0] result;
      logic [3:0] flags_out;
      logic       write_back;
      logic [2:0] target_index;
   } rsp_item_type;

endpackage

// ----- rtl/cbrsu_if.sv -----
// Valid/ready channel interfaces for the request and response items.
interface cbrsu_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] cmd;
   logic [7:0] prefix_opcode;
   logic [7:0] operand;
   logic [3:0] flags_in;

   modport source (output valid, output cmd, output prefix_opcode, output operand,
                   output flags_in, input ready);
   modport sink (input valid, input cmd, input prefix_opcode, input operand,
                 input flags_in, output ready);
endinterface

interface cbrsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result;
   logic [3:0] flags_out;
   logic       write_back;
   logic [2:0] target_index;

   modport source (output valid, output result, output flags_out, output write_back,
                   output target_index, input ready);
   modport sink (input valid, input result, input flags_out, input write_back,
                 input target_index, output ready);
endinterface

// ----- rtl/cpu_bit_rotate_shift_flag_unit.sv -----
// Bit, rotate, shift and flag unit: top level with request and response stages.
//
// Executes one 8-bit CPU instruction per item: the prefixed group (RLC, RRC,
// RL, RR, SLA, SRA, SWAP, SRL, BIT, RES, SET), RLCA/RRCA/RLA/RRA, DAA, CPL,
// SCF and CCF. Each request item carries cmd, the prefixed opcode byte, the
// operand byte and the Z/N/H/C flags; each response item returns the result
// byte, the new flags, a write-back strobe and the target register index.
// Throughput is one item per clock while the response side takes items. The
// request register takes the item when it is accepted, the execute logic
// works on it combinationally, and the response register then takes the
// result; the response is valid once it sits in the response register.
// The request side still takes an item while a finished response waits, as
// long as the request stage is empty. No state survives between items; reset
// only empties the two stages. Prefixed shifts and DAA set Z from the 8-bit
// result, and SRA sets carry from bit 0. Unused cmd codes return result 0,
// unchanged flags, no write.
module cpu_bit_rotate_shift_flag_unit (
   input logic         clock,
   input logic         reset,
   cbrsu_req_if.sink   req_chan,
   cbrsu_rsp_if.source rsp_chan
);

   cbrsu_pkg::req_item_type req_item;
   cbrsu_pkg::req_item_type op_item;
   cbrsu_pkg::rsp_item_type exec_item;
   cbrsu_pkg::rsp_item_type rsp_item;
   logic                    op_valid;
   logic                    op_ready;

   assign req_item.cmd           = req_chan.cmd;
   assign req_item.prefix_opcode = req_chan.prefix_opcode;
   assign req_item.operand       = req_chan.operand;
   assign req_item.flags_in      = req_chan.flags_in;

   // request register
   cbrsu_stage #(
      .payload_type (cbrsu_pkg::req_item_type)
   ) u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_item),
      .out_valid (op_valid),
      .out_ready (op_ready),
      .out_data  (op_item)
   );

   // execute logic
   cbrsu_exec u_exec (
      .op_item  (op_item),
      .res_item (exec_item)
   );

   // response register
   cbrsu_stage #(
      .payload_type (cbrsu_pkg::rsp_item_type)
   ) u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (op_valid),
      .in_ready  (op_ready),
      .in_data   (exec_item),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_item)
   );

   assign rsp_chan.result       = rsp_item.result;
   assign rsp_chan.flags_out    = rsp_item.flags_out;
   assign rsp_chan.write_back   = rsp_item.write_back;
   assign rsp_chan.target_index = rsp_item.target_index;

   // an accepted request lands in the request register
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> op_valid)
      else $error("accepted request item not held in request stage");

   // an executed item moves on into the response register
   a_op_moves: assert property (@(posedge clock) disable iff (reset)
      op_valid && op_ready |=> rsp_chan.valid)
      else $error("executed item lost between stages");

   // request side stalls only when both stages are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> op_valid && rsp_chan.valid && !rsp_chan.ready)
      else $error("request stalled with room in the pipeline");

   // results without write-back carry a zero byte
   a_nowb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.write_back |-> rsp_chan.result == 8'h00)
      else $error("non-written result is not zero");

   // only prefixed items target a register other than the accumulator
   a_acc_target: assert property (@(posedge clock) disable iff (reset)
      op_valid && op_item.cmd != cbrsu_pkg::CMD_PREFIX
         |-> exec_item.target_index == cbrsu_pkg::ACC_INDEX)
      else $error("accumulator op with non-accumulator target");

endmodule

// ----- rtl/cbrsu_stage.sv -----
// One valid/ready register stage; takes a new item whenever it is empty or drains.
module cbrsu_stage #(
   parameter type payload_type = cbrsu_pkg::req_item_type
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  payload_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output payload_type out_data
);

   logic        valid_ff;
   logic        valid_in;
   payload_type data_ff;
   payload_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      data_in  = (in_valid && in_ready) ? in_data : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- rtl/cbrsu_exec.sv -----
// Combinational execute logic: prefixed bit ops, accumulator rotates, DAA, CPL, SCF, CCF.
module cbrsu_exec (
   input  cbrsu_pkg::req_item_type op_item,
   output cbrsu_pkg::rsp_item_type res_item
);

   logic [7:0] x;
   logic [3:0] f;
   logic       cin;
   logic [2:0] kind;
   logic [1:0] opclass;
   logic [7:0] sh_res;
   logic       sh_c;
   logic [7:0] bit_mask;
   logic       daa_sub;
   logic       daa_low;
   logic       daa_high;
   logic [7:0] daa_adj;
   logic [7:0] daa_res;

   assign x       = op_item.operand;
   assign f       = op_item.flags_in;
   assign cin     = op_item.flags_in[cbrsu_pkg::FLAG_C];
   assign kind    = op_item.prefix_opcode[5:3];
   assign opclass = op_item.prefix_opcode[7:6];
   assign bit_mask = 8'b1 << kind;

   // prefixed shifts and rotates
   always_comb begin
      unique case (cbrsu_pkg::shift_type'(kind))
         cbrsu_pkg::SH_RLC:  begin sh_c = x[7]; sh_res = {x[6:0], x[7]};  end
         cbrsu_pkg::SH_RRC:  begin sh_c = x[0]; sh_res = {x[0], x[7:1]};  end
         cbrsu_pkg::SH_RL:   begin sh_c = x[7]; sh_res = {x[6:0], cin};   end
         cbrsu_pkg::SH_RR:   begin sh_c = x[0]; sh_res = {cin, x[7:1]};   end
         cbrsu_pkg::SH_SLA:  begin sh_c = x[7]; sh_res = {x[6:0], 1'b0};  end
         cbrsu_pkg::SH_SRA:  begin sh_c = x[0]; sh_res = {x[7], x[7:1]};  end
         cbrsu_pkg::SH_SWAP: begin sh_c = 1'b0; sh_res = {x[3:0], x[7:4]}; end
         cbrsu_pkg::SH_SRL:  begin sh_c = x[0]; sh_res = {1'b0, x[7:1]};  end
         default:            begin sh_c = 1'b0; sh_res = 8'h00;           end
      endcase
   end

   // decimal adjust: add after an addition, subtract after a subtraction
   always_comb begin
      daa_sub  = f[cbrsu_pkg::FLAG_N];
      daa_low  = f[cbrsu_pkg::FLAG_H] || (!daa_sub && (x[3:0] > cbrsu_pkg::DAA_DIGIT_LIMIT));
      daa_high = cin || (!daa_sub && (x > cbrsu_pkg::DAA_HIGH_LIMIT));
      daa_adj  = (daa_low ? cbrsu_pkg::DAA_LOW_ADJ : 8'h00)
               | (daa_high ? cbrsu_pkg::DAA_HIGH_ADJ : 8'h00);
      daa_res  = daa_sub ? (x - daa_adj) : (x + daa_adj);
   end

   always_comb begin
      res_item.result       = 8'h00;
      res_item.flags_out    = f;
      res_item.write_back   = 1'b1;
      res_item.target_index = cbrsu_pkg::ACC_INDEX;
      unique case (cbrsu_pkg::cmd_type'(op_item.cmd))
         cbrsu_pkg::CMD_PREFIX: begin
            res_item.target_index = op_item.prefix_opcode[2:0];
            unique case (cbrsu_pkg::opclass_type'(opclass))
               cbrsu_pkg::OPC_BIT: begin
                  res_item.write_back = 1'b0;
                  res_item.flags_out  = {~|(x & bit_mask), 1'b0, 1'b1, cin};
               end
               cbrsu_pkg::OPC_RES: begin
                  res_item.result = x & ~bit_mask;
               end
               cbrsu_pkg::OPC_SET: begin
                  res_item.result = x | bit_mask;
               end
               default: begin
                  res_item.result    = sh_res;
                  res_item.flags_out = {sh_res == 8'h00, 2'b00, sh_c};
               end
            endcase
         end
         cbrsu_pkg::CMD_RLCA: begin
            res_item.result    = {x[6:0], x[7]};
            res_item.flags_out = {3'b000, x[7]};
         end
         cbrsu_pkg::CMD_RRCA: begin
            res_item.result    = {x[0], x[7:1]};
            res_item.flags_out = {3'b000, x[0]};
         end
         cbrsu_pkg::CMD_RLA: begin
            res_item.result    = {x[6:0], cin};
            res_item.flags_out = {3'b000, x[7]};
         end
         cbrsu_pkg::CMD_RRA: begin
            res_item.result    = {cin, x[7:1]};
            res_item.flags_out = {3'b000, x[0]};
         end
         cbrsu_pkg::CMD_DAA: begin
            res_item.result    = daa_res;
            res_item.flags_out = {daa_res == 8'h00, daa_sub, 1'b0, daa_high};
         end
         cbrsu_pkg::CMD_CPL: begin
            res_item.result    = ~x;
            res_item.flags_out = {f[cbrsu_pkg::FLAG_Z], 2'b11, cin};
         end
         cbrsu_pkg::CMD_SCF: begin
            res_item.write_back = 1'b0;
            res_item.flags_out  = {f[cbrsu_pkg::FLAG_Z], 3'b001};
         end
         cbrsu_pkg::CMD_CCF: begin
            res_item.write_back = 1'b0;
            res_item.flags_out  = {f[cbrsu_pkg::FLAG_Z], 2'b00, ~cin};
         end
         default: begin
            // unused codes behave as a no-op
            res_item.write_back = 1'b0;
         end
      endcase
   end

endmodule

// ----- sim/cpu_bit_rotate_shift_flag_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the bit, rotate, shift and flag unit: random handshakes, predicted responses.
module cpu_bit_rotate_shift_flag_unit_tb;

   // No item in or out for this many cycles means the unit is hung
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 775;
   // Response count at which the receiver starts its long hold-off
   localparam int LONG_HOLD_AT = 400;
   localparam int LONG_HOLD_CYCLES = 300;

   logic clock;
   logic reset;

   cbrsu_req_if req_if();
   cbrsu_rsp_if rsp_if();

   cpu_bit_rotate_shift_flag_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   cbrsu_pkg::req_item_type instr_queue[$];   // items not yet accepted; [0] is on the bus
   cbrsu_pkg::rsp_item_type rsp_due[$];       // predicted responses, oldest first
   cbrsu_pkg::rsp_item_type rsp_exp;

   logic req_fired;                // request accepted at the last rising edge
   int   errors = 0;
   int   rsp_count = 0;
   int   idle_cycles = 0;

   // sender burst/gap shaping
   int   burst_left = 0;
   int   gap_left = 0;
   logic offering;

   // receiver stall pattern
   int   rx_mode = 0;
   int   rx_mode_left = 0;
   int   rx_cycle = 0;
   int   long_hold_left = 0;
   logic long_hold_done = 1'b0;
   logic rx_ready;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Predictor: one instruction on one operand byte and the Z/N/H/C flags.
   // -------------------------------------------------------------------------
   function automatic cbrsu_pkg::rsp_item_type exec_byte_op(cbrsu_pkg::req_item_type rq);
      cbrsu_pkg::rsp_item_type rs;
      logic [7:0]   x;
      logic [3:0]   f;
      logic         cin;
      logic         co;
      logic         sub;
      logic [2:0]   kind;
      logic [7:0]   adj;
      x    = rq.operand;
      f    = rq.flags_in;
      cin  = f[cbrsu_pkg::FLAG_C];
      co   = 1'b0;
      kind = rq.prefix_opcode[5:3];
      adj  = 8'h00;
      // defaults: result 0, flags pass through; unused cmd codes also drop the write
      rs.result       = 8'h00;
      rs.flags_out    = f;
      rs.write_back   = 1'b1;
      rs.target_index = cbrsu_pkg::ACC_INDEX;
      case (rq.cmd)
         cbrsu_pkg::CMD_PREFIX: begin
            rs.target_index = rq.prefix_opcode[2:0];
            case (cbrsu_pkg::opclass_type'(rq.prefix_opcode[7:6]))
               cbrsu_pkg::OPC_BIT: begin
                  // Z is the inverted tested bit, H set, C kept
                  rs.write_back = 1'b0;
                  rs.flags_out  = {~x[kind], 1'b0, 1'b1, cin};
               end
               cbrsu_pkg::OPC_RES: rs.result = x & ~(8'd1 << kind);
               cbrsu_pkg::OPC_SET: rs.result = x | (8'd1 << kind);
               default: begin
                  case (cbrsu_pkg::shift_type'(kind))
                     cbrsu_pkg::SH_RLC:  {co, rs.result} = {x, x[7]};
                     cbrsu_pkg::SH_RRC:  {rs.result, co} = {x[0], x};
                     cbrsu_pkg::SH_RL:   {co, rs.result} = {x, cin};
                     cbrsu_pkg::SH_RR:   {rs.result, co} = {cin, x};
                     cbrsu_pkg::SH_SLA:  {co, rs.result} = {x, 1'b0};
                     // sign kept, C from bit 0
                     cbrsu_pkg::SH_SRA:  {rs.result, co} = {x[7], x};
                     cbrsu_pkg::SH_SWAP: rs.result = {x[3:0], x[7:4]};
                     default: {rs.result, co} = {1'b0, x};   // SRL
                  endcase
                  rs.flags_out = {rs.result == 8'h00, 1'b0, 1'b0, co};
               end
            endcase
         end
         // accumulator rotates always clear Z, unlike the prefixed forms
         cbrsu_pkg::CMD_RLCA: begin
            {co, rs.result} = {x, x[7]};
            rs.flags_out    = {3'b000, co};
         end
         cbrsu_pkg::CMD_RRCA: begin
            {rs.result, co} = {x[0], x};
            rs.flags_out    = {3'b000, co};
         end
         cbrsu_pkg::CMD_RLA: begin
            {co, rs.result} = {x, cin};
            rs.flags_out    = {3'b000, co};
         end
         cbrsu_pkg::CMD_RRA: begin
            {rs.result, co} = {cin, x};
            rs.flags_out    = {3'b000, co};
         end
         cbrsu_pkg::CMD_DAA: begin
            // N tells whether the last op was a subtraction; digit checks only after adds
            sub = f[cbrsu_pkg::FLAG_N];
            if (f[cbrsu_pkg::FLAG_H] || (!sub && x[3:0] > cbrsu_pkg::DAA_DIGIT_LIMIT))
               adj = cbrsu_pkg::DAA_LOW_ADJ;
            if (cin || (!sub && x > cbrsu_pkg::DAA_HIGH_LIMIT)) begin
               adj = adj | cbrsu_pkg::DAA_HIGH_ADJ;
               co  = 1'b1;
            end
            rs.result    = sub ? (x - adj) : (x + adj);
            rs.flags_out = {rs.result == 8'h00, sub, 1'b0, co};
         end
         cbrsu_pkg::CMD_CPL: begin
            rs.result    = ~x;
            rs.flags_out = {f[cbrsu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
         end
         cbrsu_pkg::CMD_SCF: begin
            rs.write_back = 1'b0;
            rs.flags_out  = {f[cbrsu_pkg::FLAG_Z], 1'b0, 1'b0, 1'b1};
         end
         cbrsu_pkg::CMD_CCF: begin
            rs.write_back = 1'b0;
            rs.flags_out  = {f[cbrsu_pkg::FLAG_Z], 1'b0, 1'b0, ~cin};
         end
         default: rs.write_back = 1'b0;
      endcase
      return rs;
   endfunction

   task automatic queue_instr(input logic [3:0] cmd, input logic [7:0] opc,
                              input logic [7:0] x, input logic [3:0] f);
      cbrsu_pkg::req_item_type it;
      it.cmd           = cmd;
      it.prefix_opcode = opc;
      it.operand       = x;
      it.flags_in      = f;
      instr_queue.push_back(it);
   endtask

   // Blocks the stimulus until the unit has drained every accepted item.
   task automatic wait_drained();
      while (instr_queue.size() != 0 || rsp_due.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Driver: offers instr_queue[0] from the falling edge, holds it until taken.
   // Bursts of random length with random gaps; some long bursts have no gaps.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         offering = req_if.valid && !req_fired;
         if (req_if.valid && req_fired) void'(instr_queue.pop_front());
         if (offering) begin
            // item still on the bus: keep it there
         end else if (gap_left != 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (instr_queue.size() != 0) begin
            req_if.valid         <= 1'b1;
            req_if.cmd           <= instr_queue[0].cmd;
            req_if.prefix_opcode <= instr_queue[0].prefix_opcode;
            req_if.operand       <= instr_queue[0].operand;
            req_if.flags_in      <= instr_queue[0].flags_in;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: switches between always-ready, mostly ready, mostly stalled
   // and a fixed toggle pattern; one long hold-off fills the pipe.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
         end else begin
            rx_mode_left--;
         end
         if (!long_hold_done && rsp_count >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES;
         end
         if (long_hold_left != 0) begin
            long_hold_left--;
            rx_ready = 1'b0;
         end else begin
            case (rx_mode)
               0:       rx_ready = ($urandom_range(0, 3) != 0) || 1'b1;
               1:       rx_ready = ($urandom_range(0, 3) != 0);
               2:       rx_ready = ($urandom_range(0, 3) == 0);
               default: rx_ready = rx_cycle[2];
            endcase
         end
         rsp_if.ready <= rx_ready;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: predicts on request accept, checks on response accept.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      req_fired <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_count++;
            if (rsp_due.size() == 0) begin
               $error("response item with none outstanding: result %h flags %h",
                      rsp_if.result, rsp_if.flags_out);
               errors++;
            end else begin
               rsp_exp = rsp_due.pop_front();
               if (rsp_if.result !== rsp_exp.result) begin
                  $error("result: expected %h, got %h", rsp_exp.result, rsp_if.result);
                  errors++;
               end
               if (rsp_if.flags_out !== rsp_exp.flags_out) begin
                  $error("flags_out: expected %b, got %b", rsp_exp.flags_out,
                         rsp_if.flags_out);
                  errors++;
               end
               if (rsp_if.write_back !== rsp_exp.write_back) begin
                  $error("write_back: expected %b, got %b", rsp_exp.write_back,
                         rsp_if.write_back);
                  errors++;
               end
               if (rsp_if.target_index !== rsp_exp.target_index) begin
                  $error("target_index: expected %0d, got %0d", rsp_exp.target_index,
                         rsp_if.target_index);
                  errors++;
               end
            end
         end
         if (req_if.valid && req_if.ready)
            rsp_due.push_back(exec_byte_op({req_if.cmd, req_if.prefix_opcode,
                                            req_if.operand, req_if.flags_in}));
      end
   end

   // Watchdog: ends the run if traffic stops on both channels
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Some tests failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus: directed corners, then two random phases with a full drain
   // (sender pause) after each.
   // -------------------------------------------------------------------------
   initial begin
      logic [3:0] cmd;
      logic [7:0] opc;
      logic [7:0] x;
      logic [3:0] f;
      int         sel;

      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.cmd           = '0;
      req_if.prefix_opcode = '0;
      req_if.operand       = '0;
      req_if.flags_in      = '0;
      rsp_if.ready         = 1'b0;
      req_fired            = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // all eight prefixed shifts on single-bit operands; SLA, SRA and SRL hit zero
      for (int k = 0; k < 8; k++)
         queue_instr(cbrsu_pkg::CMD_PREFIX, {cbrsu_pkg::OPC_SHIFT, k[2:0], k[2:0]},
                     k[0] ? 8'h01 : 8'h80, k[1] ? 4'hF : 4'h0);
      // BIT: tested bit clear (Z set) and set (Z clear)
      queue_instr(cbrsu_pkg::CMD_PREFIX, {cbrsu_pkg::OPC_BIT, 3'd7, 3'd7}, 8'h00, 4'h0);
      queue_instr(cbrsu_pkg::CMD_PREFIX, {cbrsu_pkg::OPC_BIT, 3'd0, 3'd0}, 8'h01, 4'hF);
      queue_instr(cbrsu_pkg::CMD_PREFIX, {cbrsu_pkg::OPC_RES, 3'd7, 3'd6}, 8'hFF, 4'h5);
      queue_instr(cbrsu_pkg::CMD_PREFIX, {cbrsu_pkg::OPC_SET, 3'd0, 3'd0}, 8'h00, 4'hA);
      // accumulator rotates: carry in and bit 7/bit 0 out both exercised
      queue_instr(cbrsu_pkg::CMD_RLCA, 8'h00, 8'h81, 4'hF);
      queue_instr(cbrsu_pkg::CMD_RRCA, 8'hFF, 8'h81, 4'h0);
      queue_instr(cbrsu_pkg::CMD_RLA, 8'h00, 8'h81, 4'h0);
      queue_instr(cbrsu_pkg::CMD_RRA, 8'h00, 8'h00, 4'hF);
      // DAA: both corrections after add, both after subtract, zero result
      queue_instr(cbrsu_pkg::CMD_DAA, 8'h00, 8'h9A, 4'h0);
      queue_instr(cbrsu_pkg::CMD_DAA, 8'h00, 8'h00, 4'h7);
      queue_instr(cbrsu_pkg::CMD_DAA, 8'h00, 8'h00, 4'h0);
      queue_instr(cbrsu_pkg::CMD_CPL, 8'h00, 8'h00, 4'h0);
      queue_instr(cbrsu_pkg::CMD_SCF, 8'h00, 8'hFF, 4'hE);
      queue_instr(cbrsu_pkg::CMD_CCF, 8'h00, 8'hFF, 4'h1);
      queue_instr(cbrsu_pkg::CMD_CCF, 8'h00, 8'h55, 4'h0);
      // unused cmd codes are no-ops
      queue_instr(4'd9, 8'hFF, 8'hFF, 4'hA);
      queue_instr(4'd15, 8'hFF, 8'h7E, 4'h5);
      wait_drained();

      for (int phase = 0; phase < 2; phase++) begin
         repeat (ITEMS_PER_PHASE) begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
               cmd = cbrsu_pkg::CMD_PREFIX;
            else if (sel < 95)
               cmd = 4'($urandom_range(cbrsu_pkg::CMD_RLCA, cbrsu_pkg::CMD_CCF));
            else
               cmd = 4'($urandom_range(9, 15));
            opc = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 7))
               0:       x = 8'h00;
               1:       x = 8'hFF;
               2:       x = 8'h01 << $urandom_range(0, 7);
               default: x = 8'($urandom_range(0, 255));
            endcase
            f = 4'($urandom_range(0, 15));
            queue_instr(cmd, opc, x, f);
         end
         wait_drained();
      end

      // let any stray response show up before the verdict
      repeat (8) @(posedge clock);
      if (errors == 0 && rsp_due.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/cbrsu_pkg.sv
rtl/cbrsu_if.sv
rtl/cbrsu_stage.sv
rtl/cbrsu_exec.sv
rtl/cpu_bit_rotate_shift_flag_unit.sv
sim/cpu_bit_rotate_shift_flag_unit_tb.sv
